>>> hdl/dec_pkg.sv
// Shared types and constants for the depth edge classifier.
`default_nettype none

package dec_pkg;

  // Field and counter widths
  localparam int DEPTH_W    = 16;
  localparam int WORD_W     = DEPTH_W + 1;   // valid bit on top of the depth
  localparam int COUNT_W    = 10;            // full-frame position counters
  localparam int HALF_W     = 9;             // halved-image coordinates
  localparam int CFG_DIM_W  = 11;            // width / height registers
  localparam int MIN_DIM    = 6;
  localparam int MAX_HEIGHT = 1024;

  // Output FIFO
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  // Register map (index = paddr[3:2])
  localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_EDGE_THRESHOLD = 2'd2;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    CLS_SURFACE = 2'd0,
    CLS_EDGE    = 2'd1,
    CLS_SHADOW  = 2'd2,
    CLS_INVALID = 2'd3
  } class_t;

  // Center and its four neighbors
  typedef struct packed {
    word_t c;
    word_t up;
    word_t dn;
    word_t lf;
    word_t rt;
  } nbr_t;

  // Position data that follows a pixel down the pipe
  typedef struct packed {
    logic              frame_last;
    logic [HALF_W-1:0] out_row;
    logic [HALF_W-1:0] out_col;
  } meta_t;

  typedef struct packed {
    logic              frame_last;
    class_t            pixel_class;
    logic [HALF_W-1:0] out_row;
    logic [HALF_W-1:0] out_col;
  } res_t;

endpackage

`default_nettype wire

>>> hdl/dec_line_buf.sv
// Two row memories plus the column window registers around the center pixel.
`default_nettype none

module dec_line_buf
  import dec_pkg::*;
#(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,     // kept pixel transferred this cycle
  input  wire logic [AW-1:0] rd_addr,
  input  wire word_t         new_word,
  output nbr_t               nbr        // neighborhood, valid the cycle after rd_en
);

  // Row stores: upper = two kept rows back, middle = previous kept row
  word_t upper_mem [DEPTH];
  word_t middle_mem [DEPTH];

  word_t           rd_up_r;
  word_t           rd_mid_r;
  logic            s1_en_r;
  logic [AW-1:0]   s1_addr_r;
  word_t           s1_word_r;

  // Window registers
  word_t rw0_r;
  word_t rw1_r;
  word_t prev_up_r;
  word_t prev_new_r;

  // Read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_up_r  <= upper_mem[rd_addr];
      rd_mid_r <= middle_mem[rd_addr];
    end
  end

  // Write back in the cycle after the read; the same entry is not read again for at
  // least a full input row, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (s1_en_r) begin
      upper_mem[s1_addr_r]  <= rd_mid_r;
      middle_mem[s1_addr_r] <= s1_word_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_en_r <= 1'b0;
    end else begin
      s1_en_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_addr_r <= rd_addr;
      s1_word_r <= new_word;
    end
  end

  // Slide the window on every kept pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rw0_r      <= '0;
      rw1_r      <= '0;
      prev_up_r  <= '0;
      prev_new_r <= '0;
    end else if (s1_en_r) begin
      rw0_r      <= rw1_r;
      rw1_r      <= rd_mid_r;
      prev_up_r  <= rd_up_r;
      prev_new_r <= s1_word_r;
    end
  end

  assign nbr.c  = rw1_r;
  assign nbr.up = prev_up_r;
  assign nbr.dn = prev_new_r;
  assign nbr.lf = rw0_r;
  assign nbr.rt = rd_mid_r;

endmodule

`default_nettype wire

>>> hdl/dec_classify.sv
// Min/max over the neighborhood, then threshold compare into a class.
`default_nettype none

module dec_classify
  import dec_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire nbr_t               nbr,
  input  wire meta_t              meta,
  input  wire logic [DEPTH_W-1:0] threshold,
  output logic                    res_valid,
  output res_t                    res
);

  function automatic logic [DEPTH_W-1:0] min16(input logic [DEPTH_W-1:0] a,
                                               input logic [DEPTH_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [DEPTH_W-1:0] max16(input logic [DEPTH_W-1:0] a,
                                               input logic [DEPTH_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  logic [DEPTH_W-1:0] cd;
  logic [DEPTH_W-1:0] lo_up, lo_dn, lo_lf, lo_rt;
  logic [DEPTH_W-1:0] hi_up, hi_dn, hi_lf, hi_rt;
  logic [DEPTH_W-1:0] lo_all, hi_all;

  logic               s2_valid_r;
  meta_t              s2_meta_r;
  logic               s2_cvalid_r;
  logic [DEPTH_W-1:0] s2_cd_r;
  logic [DEPTH_W-1:0] s2_lo_r;
  logic [DEPTH_W-1:0] s2_hi_r;
  class_t             cls;

  // Invalid neighbors fall back to the center so they drop out
  always_comb begin
    cd    = nbr.c[DEPTH_W-1:0];
    lo_up = nbr.up[DEPTH_W] ? nbr.up[DEPTH_W-1:0] : cd;
    lo_dn = nbr.dn[DEPTH_W] ? nbr.dn[DEPTH_W-1:0] : cd;
    lo_lf = nbr.lf[DEPTH_W] ? nbr.lf[DEPTH_W-1:0] : cd;
    lo_rt = nbr.rt[DEPTH_W] ? nbr.rt[DEPTH_W-1:0] : cd;
    hi_up = lo_up;
    hi_dn = lo_dn;
    hi_lf = lo_lf;
    hi_rt = lo_rt;
    lo_all = min16(min16(min16(lo_up, lo_dn), min16(lo_lf, lo_rt)), cd);
    hi_all = max16(max16(max16(hi_up, hi_dn), max16(hi_lf, hi_rt)), cd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      s2_meta_r   <= meta;
      s2_cvalid_r <= nbr.c[DEPTH_W];
      s2_cd_r     <= cd;
      s2_lo_r     <= lo_all;
      s2_hi_r     <= hi_all;
    end
  end

  // Shadow edge takes precedence over edge
  always_comb begin
    priority if (!s2_cvalid_r) begin
      cls = CLS_INVALID;
    end else if ((s2_cd_r - s2_lo_r) > threshold) begin
      cls = CLS_SHADOW;
    end else if ((s2_hi_r - s2_cd_r) > threshold) begin
      cls = CLS_EDGE;
    end else begin
      cls = CLS_SURFACE;
    end
  end

  assign res_valid       = s2_valid_r;
  assign res.frame_last  = s2_meta_r.frame_last;
  assign res.pixel_class = cls;
  assign res.out_row     = s2_meta_r.out_row;
  assign res.out_col     = s2_meta_r.out_col;

endmodule

`default_nettype wire

>>> hdl/dec_out_fifo.sv
// Small result FIFO that decouples the pipeline from output backpressure.
`default_nettype none

module dec_out_fifo
  import dec_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire res_t                  push_data,
  input  wire logic                  pop_ready,
  output logic                       pop_valid,
  output res_t                       pop_data,
  output logic [FIFO_CNT_W-1:0]      count
);

  res_t                  entry_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r;
  logic                  pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (count_r != '0);
  assign pop_data  = entry_r[rd_ptr_r];
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/depth_edge_classifier.sv
// Pipeline: for the kept pixel that completes a neighborhood, the registered memory
//   read and min/max come first, then the compare into a 4-entry output FIFO.
// Throughput: one input pixel per cycle while in_tready is high, the FIFO absorbing
//   output stalls; the two row memories take one read and one write per kept pixel.
// Reset: synchronous, active low; clears counters, window and FIFO and loads
//   width 640, height 480, threshold 20. Row memories need no clearing.
`default_nettype none

module depth_edge_classifier
  import dec_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] depth_mm
  input  wire logic [0:0]  in_tuser,   // [0] depth_valid
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [8:0] out_col, [17:9] out_row, [23:18] zero
  output logic [1:0]       out_tuser,  // [1:0] pixel_class
  output logic             out_tlast,  // frame_last
  // Configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int HALF_MAX = MAX_WIDTH / 2;
  localparam int AW       = $clog2(HALF_MAX);
  localparam int DW       = ($clog2(MAX_WIDTH + 1) > CFG_DIM_W) ?
                            $clog2(MAX_WIDTH + 1) : CFG_DIM_W;

  // Configuration registers
  logic [CFG_DIM_W-1:0] frame_width_r;
  logic [CFG_DIM_W-1:0] frame_height_r;
  logic [DEPTH_W-1:0]   edge_threshold_r;
  logic                 cfg_wr;
  logic [1:0]           cfg_idx;

  // Position counters
  logic [COUNT_W-1:0]   col_r, col_nxt;
  logic [COUNT_W-1:0]   row_r, row_nxt;

  logic                 in_xfer;
  logic [DW-1:0]        w_clamp, w_half, fw_ext;
  logic [CFG_DIM_W-1:0] h_clamp, h_half;
  logic [HALF_W-1:0]    hc, hr;
  logic                 kept, emit;
  logic [CFG_DIM_W-1:0] col_inc, row_inc;
  logic [AW-1:0]        mem_addr;
  word_t                new_word;
  meta_t                meta_s0;

  logic                 s1_emit_r;
  meta_t                s1_meta_r;
  nbr_t                 nbr;
  logic                 res_valid;
  res_t                 res;
  res_t                 fifo_data;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [FIFO_CNT_W-1:0] in_flight;

  // APB access
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= CFG_DIM_W'(640);
      frame_height_r   <= CFG_DIM_W'(480);
      edge_threshold_r <= DEPTH_W'(20);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:    frame_width_r    <= cfg_pwdata[CFG_DIM_W-1:0];
        REG_FRAME_HEIGHT:   frame_height_r   <= cfg_pwdata[CFG_DIM_W-1:0];
        REG_EDGE_THRESHOLD: edge_threshold_r <= cfg_pwdata[DEPTH_W-1:0];
        default:            ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:    cfg_prdata = 32'(frame_width_r);
      REG_FRAME_HEIGHT:   cfg_prdata = 32'(frame_height_r);
      REG_EDGE_THRESHOLD: cfg_prdata = 32'(edge_threshold_r);
      default:            cfg_prdata = '0;
    endcase
  end

  // Clamped frame size and halved size
  always_comb begin
    fw_ext = DW'(frame_width_r);
    if (fw_ext < DW'(MIN_DIM)) begin
      w_clamp = DW'(MIN_DIM);
    end else if (fw_ext > DW'(MAX_WIDTH)) begin
      w_clamp = DW'(MAX_WIDTH);
    end else begin
      w_clamp = fw_ext;
    end
    if (frame_height_r < CFG_DIM_W'(MIN_DIM)) begin
      h_clamp = CFG_DIM_W'(MIN_DIM);
    end else if (frame_height_r > CFG_DIM_W'(MAX_HEIGHT)) begin
      h_clamp = CFG_DIM_W'(MAX_HEIGHT);
    end else begin
      h_clamp = frame_height_r;
    end
    w_half = w_clamp >> 1;
    h_half = h_clamp >> 1;
  end

  // Decimation and window position of the current transfer
  assign in_xfer  = in_tvalid && in_tready;
  assign hc       = col_r[COUNT_W-1:1];
  assign hr       = row_r[COUNT_W-1:1];
  assign kept     = in_xfer && !col_r[0] && !row_r[0] &&
                    (DW'(hc) < w_half) && (CFG_DIM_W'(hr) < h_half);
  assign emit     = kept && (hr >= HALF_W'(2)) && (hc >= HALF_W'(2));
  assign mem_addr = AW'(hc);
  assign new_word = {in_tuser[0], in_tdata};

  assign meta_s0.out_col    = hc - HALF_W'(1);
  assign meta_s0.out_row    = hr - HALF_W'(1);
  assign meta_s0.frame_last = (CFG_DIM_W'(hr) == h_half - CFG_DIM_W'(1)) &&
                              (DW'(hc) == w_half - DW'(1));

  // Raster counters; wrap on the clamped size
  always_comb begin
    col_inc = CFG_DIM_W'(col_r) + CFG_DIM_W'(1);
    row_inc = CFG_DIM_W'(row_r) + CFG_DIM_W'(1);
    col_nxt = col_inc[COUNT_W-1:0];
    row_nxt = row_r;
    if (DW'(col_inc) >= w_clamp) begin
      col_nxt = '0;
      row_nxt = (row_inc >= h_clamp) ? '0 : row_inc[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_wr && (cfg_idx == REG_FRAME_WIDTH || cfg_idx == REG_FRAME_HEIGHT)) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_xfer) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Stage 1 bookkeeping alongside the memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_emit_r <= 1'b0;
    end else begin
      s1_emit_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      s1_meta_r <= meta_s0;
    end
  end

  dec_line_buf #(
    .DEPTH (HALF_MAX),
    .AW    (AW)
  ) u_line_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (kept),
    .rd_addr  (mem_addr),
    .new_word (new_word),
    .nbr      (nbr)
  );

  dec_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_emit_r),
    .nbr       (nbr),
    .meta      (s1_meta_r),
    .threshold (edge_threshold_r),
    .res_valid (res_valid),
    .res       (res)
  );

  dec_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .pop_ready (out_tready),
    .pop_valid (out_tvalid),
    .pop_data  (fifo_data),
    .count     (fifo_count)
  );

  // Accept only while the FIFO has room for everything in flight plus one more
  assign in_flight = fifo_count + FIFO_CNT_W'(s1_emit_r) + FIFO_CNT_W'(res_valid);
  assign in_tready = (in_flight < FIFO_CNT_W'(FIFO_DEPTH));

  assign out_tdata = {6'b0, fifo_data.out_row, fifo_data.out_col};
  assign out_tuser = fifo_data.pixel_class;
  assign out_tlast = fifo_data.frame_last;

endmodule

`default_nettype wire

>>> hdl/dec_checker.sv
// Port-level checks for the depth edge classifier, bound to the top level.
`default_nettype none

module dec_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast,
  input wire logic        cfg_psel,
  input wire logic        cfg_pready
);

  // A stalled result transfer holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Only interior pixels are classed: column and row are never zero
  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[8:0] != 9'd0) && (out_tdata[17:9] != 9'd0))
    else $error("classified pixel on the border");

  // Padding bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:18] == 6'd0)
    else $error("nonzero padding in out_tdata");

  // Nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // Configuration port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel |-> cfg_pready)
    else $error("cfg_pready low");

endmodule

bind depth_edge_classifier dec_checker u_dec_checker (.*);

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the depth edge classifier: stream, APB and class prediction.
`timescale 1ns / 100ps

module tb
  import dec_pkg::*;
();

  localparam int          MAX_W        = 1024;
  localparam int          STALL_LIMIT  = 2000;  // cycles with no transfer before giving up
  localparam int          DRAIN_CYCLES = 10;    // pipeline is three deep, leave some margin
  localparam int          PRINT_CAP    = 40;
  localparam logic [1:0]  REG_UNUSED   = 2'd3;  // beyond the register map

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata    = '0;   // [15:0] depth_mm
  logic [0:0]  in_tuser    = '0;   // [0] depth_valid
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [23:0] out_tdata;          // [8:0] out_col, [17:9] out_row, [23:18] zero
  logic [1:0]  out_tuser;          // [1:0] pixel_class
  logic        out_tlast;          // frame_last
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  depth_edge_classifier #(.MAX_WIDTH(MAX_W)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Shadow of the block: registers, line stores, position and window
  logic [CFG_DIM_W-1:0] width_reg  = 11'd640;
  logic [CFG_DIM_W-1:0] height_reg = 11'd480;
  logic [DEPTH_W-1:0]   thresh_reg = 16'd20;
  word_t                line_upper  [0:MAX_W/2-1];
  word_t                line_middle [0:MAX_W/2-1];
  int                   col_pos, row_pos;
  word_t                win_left, win_center, prev_up, prev_new;

  res_t  expected_pixels[$];
  word_t kept_grid [0:2][0:4];     // kept pixels of a 10x6 directed frame

  int send_idle_pct, stall_pct;
  int pixel_count, result_count, cfg_count, err_count;
  int idle_cycles;

  function automatic int clamp_dim(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Class of a center from its four neighbors; invalid neighbors drop out
  function automatic class_t class_of(input word_t c, input word_t up, input word_t dn,
                                      input word_t lf, input word_t rt);
    logic [3:0][WORD_W-1:0] nbr;
    int cd, lo, hi, d;
    if (!c[DEPTH_W]) return CLS_INVALID;
    nbr = {up, dn, lf, rt};
    cd  = c[DEPTH_W-1:0];
    lo  = cd;
    hi  = cd;
    for (int i = 0; i < 4; i++) begin
      if (nbr[i][DEPTH_W]) begin
        d = nbr[i][DEPTH_W-1:0];
        if (d < lo) lo = d;
        if (d > hi) hi = d;
      end
    end
    if (cd - lo > thresh_reg) return CLS_SHADOW;
    if (hi - cd > thresh_reg) return CLS_EDGE;
    return CLS_SURFACE;
  endfunction

  // Advance the shadow by one accepted pixel, queue the class it completes
  task automatic track_pixel(input word_t wd);
    int    w, h, hc, hr;
    word_t u, m;
    res_t  r;
    w  = clamp_dim(width_reg, MIN_DIM, MAX_W);
    h  = clamp_dim(height_reg, MIN_DIM, MAX_HEIGHT);
    hc = col_pos >> 1;
    hr = row_pos >> 1;
    if (col_pos % 2 == 0 && row_pos % 2 == 0 && hc < w / 2 && hr < h / 2) begin
      u = line_upper[hc];
      m = line_middle[hc];
      if (hr >= 2 && hc >= 2) begin
        r.out_col     = HALF_W'(hc - 1);
        r.out_row     = HALF_W'(hr - 1);
        r.pixel_class = class_of(win_center, prev_up, prev_new, win_left, m);
        r.frame_last  = (hr == h / 2 - 1) && (hc == w / 2 - 1);
        expected_pixels = {expected_pixels, r};
      end
      line_upper[hc]  = m;
      line_middle[hc] = wd;
      win_left        = win_center;
      win_center      = m;
      prev_up         = u;
      prev_new        = wd;
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic apply_reg(input logic [1:0] idx, input logic [31:0] value);
    case (idx)
      REG_FRAME_WIDTH: begin
        width_reg = value[CFG_DIM_W-1:0];
        col_pos   = 0;
        row_pos   = 0;
      end
      REG_FRAME_HEIGHT: begin
        height_reg = value[CFG_DIM_W-1:0];
        col_pos    = 0;
        row_pos    = 0;
      end
      REG_EDGE_THRESHOLD: thresh_reg = value[DEPTH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input int want, input int got);
    if (err_count < PRINT_CAP)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    err_count++;
  endtask

  // APB write; bits above the field are filled with noise
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] data;
    data = value | ($urandom << ((idx == REG_EDGE_THRESHOLD) ? DEPTH_W : CFG_DIM_W));
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    apply_reg(idx, data);
    cfg_count++;
    @(posedge clk);
  endtask

  // APB read and compare against the shadow value
  task automatic check_reg(input logic [1:0] idx, input logic [31:0] want);
    logic [31:0] got;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    got         = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_count++;
    if (got !== want) report_mismatch("register read", want, got);
    @(posedge clk);
  endtask

  // One pixel transfer with random idle cycles ahead of it
  task automatic send_pixel(input word_t wd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= wd[DEPTH_W-1:0];
    in_tuser  <= wd[DEPTH_W];
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_pixel(wd);
    pixel_count++;
  endtask

  // Stop sending and let every queued class come out
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Depth near a running base so that classes mix; some noise and holes
  function automatic word_t rand_pixel(input int base, input int thr);
    int k, span, d;
    k    = $urandom_range(99);
    span = (thr > 2000) ? 2000 : thr + 3;
    if (k < 6)  return {1'b0, 16'($urandom)};
    if (k < 12) return {1'b1, 16'($urandom)};
    d = base + $urandom_range(0, 2 * span) - span;
    if (d < 0) d = 0;
    if (d > 65535) d = 65535;
    return {1'b1, 16'(d)};
  endfunction

  function automatic int pick_dim(input int hi_typ, input int hi_wide);
    int k;
    k = $urandom_range(99);
    if (k < 12) return $urandom_range(0, MIN_DIM - 1);   // clamps up to the minimum
    if (k < 20) return $urandom_range(hi_typ + 1, hi_wide);
    return $urandom_range(MIN_DIM, hi_typ);
  endfunction

  function automatic int pick_threshold();
    int k;
    k = $urandom_range(99);
    if (k < 15) return 0;
    if (k < 25) return 65535;
    if (k < 80) return $urandom_range(1, 64);
    return $urandom & 32'hFFFF;
  endfunction

  // Send a 10x6 frame: kept pixels from the grid, the dropped ones random
  task automatic send_grid_frame();
    for (int r = 0; r < 6; r++) begin
      for (int c = 0; c < 10; c++) begin
        if (r % 2 == 0 && c % 2 == 0) send_pixel(kept_grid[r/2][c/2]);
        else send_pixel(17'($urandom));
      end
    end
  endtask

  // Stream of random pixels at one size setting
  task automatic send_random_pixels(input int n, input int thr);
    int base;
    base = $urandom_range(0, 65535);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(39) == 0) base = $urandom_range(0, 65535);
      send_pixel(rand_pixel(base, thr));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Register map: reset values, every register, the unmapped index
  task automatic test_register_access();
    check_reg(REG_FRAME_WIDTH, 32'd640);
    check_reg(REG_FRAME_HEIGHT, 32'd480);
    check_reg(REG_EDGE_THRESHOLD, 32'd20);
    write_reg(REG_FRAME_WIDTH, 32'd2047);
    write_reg(REG_FRAME_HEIGHT, 32'd1);
    write_reg(REG_EDGE_THRESHOLD, 32'd65535);
    write_reg(REG_UNUSED, 32'h7FF);
    check_reg(REG_FRAME_WIDTH, width_reg);
    check_reg(REG_FRAME_HEIGHT, height_reg);
    check_reg(REG_EDGE_THRESHOLD, thresh_reg);
  endtask

  // Hand-built neighborhoods: each class, thresholds at the boundary, holes
  task automatic test_directed_classes();
    write_reg(REG_FRAME_WIDTH, 32'd10);
    write_reg(REG_FRAME_HEIGHT, 32'd6);
    write_reg(REG_EDGE_THRESHOLD, 32'd20);
    // shadow, edge next to it, invalid center
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 5; c++) kept_grid[r][c] = {1'b1, 16'd500};
    kept_grid[1][1] = {1'b1, 16'd530};
    kept_grid[1][3] = {1'b0, 16'd0};
    send_grid_frame();
    wait_idle();
    // step equal to the threshold, invalid neighbor at depth zero, full-scale step
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 5; c++) kept_grid[r][c] = {1'b1, 16'd1000};
    kept_grid[1][1] = {1'b1, 16'd1020};
    kept_grid[0][2] = {1'b0, 16'd0};
    kept_grid[1][3] = {1'b1, 16'd65535};
    kept_grid[0][3] = {1'b1, 16'd0};
    send_grid_frame();
    wait_idle();
    // same frame, largest threshold: nothing exceeds it
    write_reg(REG_EDGE_THRESHOLD, 32'd65535);
    send_grid_frame();
    wait_idle();
  endtask

  // Random sizes and thresholds under one idling pattern
  task automatic test_random_traffic(input int idle_pct, input int stall);
    int w, h, thr, fs, n;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    repeat (2) begin
      w   = pick_dim(16, 40);
      h   = pick_dim(12, 20);
      thr = pick_threshold();
      write_reg(REG_FRAME_WIDTH, w);
      write_reg(REG_FRAME_HEIGHT, h);
      write_reg(REG_EDGE_THRESHOLD, thr);
      fs = clamp_dim(w, MIN_DIM, MAX_W) * clamp_dim(h, MIN_DIM, MAX_HEIGHT);
      n  = fs + $urandom_range(0, fs / 2);
      send_random_pixels(n / 2, thr);
      // threshold change in the middle of a frame, no restart
      if ($urandom_range(1) == 1) begin
        wait_idle();
        thr = pick_threshold();
        write_reg(REG_EDGE_THRESHOLD, thr);
      end
      send_random_pixels(n - n / 2, thr);
      wait_idle();
    end
  endtask

  // Sizes past the register limits: part of a clamped full-width line, then a
  // narrow frame set taller than the height limit
  task automatic test_size_extremes();
    int thr;
    send_idle_pct = 34;
    stall_pct     = 34;
    thr = pick_threshold();
    write_reg(REG_FRAME_WIDTH, 32'd2047);
    write_reg(REG_FRAME_HEIGHT, 32'd2047);
    write_reg(REG_EDGE_THRESHOLD, thr);
    send_random_pixels(MAX_W / 4 + $urandom_range(0, 40), thr);
    wait_idle();
    thr = pick_threshold();
    write_reg(REG_FRAME_WIDTH, 32'd6);
    write_reg(REG_FRAME_HEIGHT, 32'd2047);
    write_reg(REG_EDGE_THRESHOLD, thr);
    send_random_pixels(MAX_W / 4 + $urandom_range(0, 40), thr);
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random backpressure
  always @(posedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      result_count++;
      if (expected_pixels.size() == 0) begin
        if (err_count < PRINT_CAP)
          $display("%0t: unexpected result, expected none, actual col %0d row %0d",
                   $time, out_tdata[HALF_W-1:0], out_tdata[2*HALF_W-1:HALF_W]);
        err_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_tdata[HALF_W-1:0] !== want.out_col)
          report_mismatch("out_col", want.out_col, out_tdata[HALF_W-1:0]);
        if (out_tdata[2*HALF_W-1:HALF_W] !== want.out_row)
          report_mismatch("out_row", want.out_row, out_tdata[2*HALF_W-1:HALF_W]);
        if (out_tuser !== want.pixel_class)
          report_mismatch("pixel_class", want.pixel_class, out_tuser);
        if (out_tlast !== want.frame_last)
          report_mismatch("frame_last", want.frame_last, out_tlast);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sequence
  initial begin
    for (int i = 0; i < MAX_W / 2; i++) begin
      line_upper[i]  = '0;
      line_middle[i] = '0;
    end
    col_pos       = 0;
    row_pos       = 0;
    win_left      = '0;
    win_center    = '0;
    prev_up       = '0;
    prev_new      = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    pixel_count   = 0;
    result_count  = 0;
    cfg_count     = 0;
    err_count     = 0;
    idle_cycles   = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_access();
    test_directed_classes();
    test_random_traffic(0, 0);
    test_random_traffic(87, 0);
    test_random_traffic(0, 87);
    test_random_traffic(34, 34);
    test_size_extremes();
    wait_idle();

    $display("Sent %0d pixels, checked %0d classified pixels, %0d register accesses",
             pixel_count, result_count, cfg_count);
    $display("Sizes from the clamped minimum to past the register limits, thresholds 0 to 65535");
    if (err_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/dec_pkg.sv
hdl/dec_line_buf.sv
hdl/dec_classify.sv
hdl/dec_out_fifo.sv
hdl/depth_edge_classifier.sv
hdl/dec_checker.sv
tb/tb.sv
